>>> hdl/controller_key_repeat_generator_macros.svh
// ----------------------------------------------------------------------------
// Key repeat generator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTROLLER_KEY_REPEAT_GENERATOR_MACROS_SVH
`define CONTROLLER_KEY_REPEAT_GENERATOR_MACROS_SVH

// same-cycle implication
`define CKRG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ckrg_pkg.sv
// ----------------------------------------------------------------------------
// Key repeat generator package
// Channel counts, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package ckrg_pkg;

  localparam int NUM_BUTTONS      = 15;
  localparam int NUM_STICK_HALVES = 8;
  localparam int NUM_TRIGGERS     = 2;
  localparam int NUM_CHANNELS     = NUM_BUTTONS + NUM_STICK_HALVES + NUM_TRIGGERS;
  localparam int CH_IDX_W         = $clog2(NUM_CHANNELS);

  localparam int CH_W     = 5;
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 15;
  localparam int DELAY_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // parity of the first stick channel: picks negative/positive half
  localparam logic STICK_BASE_ODD = 1'(NUM_BUTTONS % 2);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MENU_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STICK_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INT  = 3'd5;

  localparam logic [THR_W-1:0]   STICK_THR_RST   = 15'd29491;
  localparam logic [THR_W-1:0]   TRIGGER_THR_RST = 15'd6553;
  localparam logic [DELAY_W-1:0] INIT_DELAY_RST  = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_INT_RST  = 16'd100;

endpackage

>>> hdl/controller_key_repeat_generator.sv
// ----------------------------------------------------------------------------
// Controller key repeat generator
// Turns per-channel controller samples into typematic key-down / key-up
// transfers, with initial delay and repeat interval per held channel.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   in_channel, in_sample, in_now
//  out_     output     out_valid / out_stall out_key_channel, out_key_down
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
//  One sample transfer per cycle unless an event waits on an output stall;
//  a key event passes the input register, then the result register.
//  Pressed bits and deadlines are flip-flops read and written in the same
//  stage, so consecutive samples on one channel need no forwarding.
//  Reset (rst_n low, synchronous) empties both stages, clears all pressed
//  bits and deadlines and loads the register defaults.
//  A stalled result holds; samples that cause no event keep retiring
//  under an output stall, one causing an event waits in the input register.
`include "controller_key_repeat_generator_macros.svh"

module controller_key_repeat_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ckrg_pkg::CH_W-1:0]           in_channel,
  input  logic signed [ckrg_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [ckrg_pkg::TIME_W-1:0]         in_now,
  // key event channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ckrg_pkg::CH_W-1:0]           out_key_channel,
  output logic                                out_key_down,
  // configuration
  input  logic                                cfg_we,
  input  logic [ckrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ckrg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NCH = ckrg_pkg::NUM_CHANNELS;
  localparam int IW  = ckrg_pkg::CH_IDX_W;
  localparam int TW  = ckrg_pkg::TIME_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic                             enable_r;
  logic                             menu_mode_r;
  logic [ckrg_pkg::THR_W-1:0]       stick_thr_r;
  logic [ckrg_pkg::THR_W-1:0]       trigger_thr_r;
  logic [ckrg_pkg::DELAY_W-1:0]     init_delay_r;
  logic [ckrg_pkg::DELAY_W-1:0]     repeat_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      menu_mode_r   <= 1'b0;
      stick_thr_r   <= ckrg_pkg::STICK_THR_RST;
      trigger_thr_r <= ckrg_pkg::TRIGGER_THR_RST;
      init_delay_r  <= ckrg_pkg::INIT_DELAY_RST;
      repeat_int_r  <= ckrg_pkg::REPEAT_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ckrg_pkg::REG_ENABLE:      enable_r      <= cfg_wdata[0];
        ckrg_pkg::REG_MENU_MODE:   menu_mode_r   <= cfg_wdata[0];
        ckrg_pkg::REG_STICK_THR:   stick_thr_r   <= cfg_wdata[ckrg_pkg::THR_W-1:0];
        ckrg_pkg::REG_TRIGGER_THR: trigger_thr_r <= cfg_wdata[ckrg_pkg::THR_W-1:0];
        ckrg_pkg::REG_INIT_DELAY:  init_delay_r  <= cfg_wdata[ckrg_pkg::DELAY_W-1:0];
        ckrg_pkg::REG_REPEAT_INT:  repeat_int_r  <= cfg_wdata[ckrg_pkg::DELAY_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result register state (read by the input side's handshake)
  // --------------------------------------------------------------------------
  logic                      out_valid_r, out_valid_nxt;
  logic [ckrg_pkg::CH_W-1:0] out_ch_r;
  logic                      out_down_r;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                                 s1_valid_r, s1_valid_nxt;
  logic [ckrg_pkg::CH_W-1:0]            s1_ch_r;
  logic signed [ckrg_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [TW-1:0]                        s1_now_r;

  logic in_xfer;
  logic s1_fire;
  logic s1_res;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  // an item with no event never waits on the output side
  assign s1_fire  = s1_valid_r && (!s1_res || out_free);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r     <= in_channel;
      s1_sample_r <= in_sample;
      s1_now_r    <= in_now;
    end
  end

  // --------------------------------------------------------------------------
  // per-channel state
  // --------------------------------------------------------------------------
  logic [NCH-1:0] pressed_r;
  logic [TW-1:0]  deadline_r [NCH];

  // --------------------------------------------------------------------------
  // classify and decide
  // --------------------------------------------------------------------------
  logic [IW-1:0]                     s1_idx;
  logic                              s1_ok;
  logic                              s1_is_btn, s1_is_stick;
  logic                              s1_neg_half;
  logic signed [ckrg_pkg::SAMPLE_W:0] s1_samp_x, s1_st_x, s1_tt_x;
  logic                              s1_is, s1_was, s1_emits;
  logic [TW-1:0]                     s1_diff;
  logic                              s1_reached;
  logic                              s1_down;
  logic [TW-1:0]                     s1_dl_press, s1_dl_repeat;

  assign s1_idx      = IW'(s1_ch_r);
  assign s1_ok       = enable_r && ({27'd0, s1_ch_r} < 32'(NCH));
  assign s1_is_btn   = {27'd0, s1_ch_r} < 32'(ckrg_pkg::NUM_BUTTONS);
  assign s1_is_stick = !s1_is_btn &&
                       ({27'd0, s1_ch_r} <
                        32'(ckrg_pkg::NUM_BUTTONS + ckrg_pkg::NUM_STICK_HALVES));
  // even offset from the first stick channel is the negative half
  assign s1_neg_half = (s1_ch_r[0] ^ ckrg_pkg::STICK_BASE_ODD) == 1'b0;

  // 17-bit signed compares against the raw sample
  assign s1_samp_x = {s1_sample_r[ckrg_pkg::SAMPLE_W-1], s1_sample_r};
  assign s1_st_x   = $signed({2'b00, stick_thr_r});
  assign s1_tt_x   = $signed({2'b00, trigger_thr_r});

  always_comb begin
    priority if (s1_is_btn) begin
      s1_is = s1_sample_r != '0;
    end else if (s1_is_stick) begin
      s1_is = s1_neg_half ? (s1_samp_x < -s1_st_x) : (s1_samp_x > s1_st_x);
    end else begin
      s1_is = s1_samp_x > s1_tt_x;
    end
  end

  assign s1_emits = !s1_is_stick || menu_mode_r;
  assign s1_was   = s1_ok && pressed_r[s1_idx];

  // wrap-safe: due once (now - deadline) is non-negative
  assign s1_diff    = s1_now_r - deadline_r[s1_idx];
  assign s1_reached = !s1_diff[TW-1];

  assign s1_res  = s1_ok && s1_emits &&
                   ((s1_was && !s1_is) || (!s1_was && s1_is) || (s1_is && s1_reached));
  assign s1_down = s1_is;

  assign s1_dl_press  = s1_now_r + {{(TW-ckrg_pkg::DELAY_W){1'b0}}, init_delay_r};
  assign s1_dl_repeat = s1_now_r + {{(TW-ckrg_pkg::DELAY_W){1'b0}}, repeat_int_r};

  // --------------------------------------------------------------------------
  // state update, at most once per retiring item (only while enabled and in range)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      for (int i = 0; i < NCH; i++) begin
        deadline_r[i] <= '0;
      end
    end else if (s1_fire && s1_ok) begin
      pressed_r[s1_idx] <= s1_is;
      if (s1_emits) begin
        priority if (s1_was && !s1_is) begin
          deadline_r[s1_idx] <= '0;
        end else if (!s1_was && s1_is) begin
          deadline_r[s1_idx] <= s1_dl_press;
        end else if (s1_is && s1_reached) begin
          deadline_r[s1_idx] <= s1_dl_repeat;
        end else begin
          // still released, or held and not yet due
          deadline_r[s1_idx] <= deadline_r[s1_idx];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  assign out_valid_nxt = out_free ? (s1_fire && s1_res) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_fire && s1_res) begin
      out_ch_r   <= s1_ch_r;
      out_down_r <= s1_down;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_channel = out_ch_r;
  assign out_key_down    = out_down_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CKRG_ASSERT_NEXT(a_event_matches_pressed, s1_fire && s1_res,
    out_valid_r && (out_down_r == pressed_r[IW'(out_ch_r)]),
    "key event disagrees with stored pressed bit")
  `CKRG_ASSERT_NEXT(a_release_clears_deadline, s1_fire && s1_res && !s1_is,
    deadline_r[IW'(out_ch_r)] == '0, "release left a deadline armed")
  `CKRG_ASSERT_NEXT(a_press_arms_delay, s1_fire && s1_res && !s1_was && s1_is,
    deadline_r[IW'(out_ch_r)] == $past(s1_dl_press), "press did not arm initial delay")
  `CKRG_ASSERT_SAME(a_disabled_silent, s1_valid_r && !enable_r, !s1_res,
    "event raised while disabled")

endmodule
